// ===== src/srt_pkg.sv =====
// shared types and codes of the shortest remaining time scheduler
package srt_pkg;

	// operation codes carried on the action port
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// width of the reported pool occupancy
	localparam int OCC_W  = 5;
	// width of a job's service time
	localparam int TIME_W = 16;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ADD   = 5'b00010,
		S_SCAN  = 5'b00100,
		S_LAST  = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

	// control from the sequencer to the minimum search unit
	typedef struct packed {
		logic clear;   // start of a new search
		logic sample;  // read data of the previous cycle is to be compared
		logic valid;   // the entry being compared holds a job
	} scan_ctl_t;

endpackage

// ===== src/srt_store.sv =====
// storage of the remaining service times, one write and one registered read port
module srt_store #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 rd_en,
	input  logic [$clog2(CAPACITY)-1:0]          rd_addr,
	output logic [srt_pkg::TIME_W-1:0]           rd_data,
	input  logic                                 wr_en,
	input  logic [$clog2(CAPACITY)-1:0]          wr_addr,
	input  logic [srt_pkg::TIME_W-1:0]           wr_data
);

	logic [srt_pkg::TIME_W-1:0] mem [CAPACITY];

	// registered synchronous read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== src/srt_scan.sv =====
// running minimum over the stored times, one entry compared per cycle
module srt_scan #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  srt_pkg::scan_ctl_t                   ctl,
	input  logic [srt_pkg::TIME_W-1:0]           rd_data,
	input  logic [$clog2(CAPACITY)-1:0]          idx_s1,
	output logic [srt_pkg::TIME_W-1:0]           best_time,
	output logic [$clog2(CAPACITY)-1:0]          best_idx
);

	logic                              have_q;
	logic [srt_pkg::TIME_W-1:0]        best_time_q;
	logic [$clog2(CAPACITY)-1:0]       best_idx_q;
	logic                              take;

	// strict compare keeps the lowest slot on equal times
	assign take = ctl.sample && ctl.valid && (!have_q || (rd_data < best_time_q));

	// flag of a found job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	// best candidate so far
	always_ff @(posedge clk) begin
		if (take) begin
			best_time_q <= rd_data;
			best_idx_q  <= idx_s1;
		end
	end

	assign best_time = best_time_q;
	assign best_idx  = best_idx_q;

endmodule

// ===== src/shortest_remaining_time_scheduler.sv =====
// top level of the shortest remaining time scheduler: sequencer, valid bits and job count
//
// A word is taken when start is high and busy is low; its result appears on the result
// ports for one cycle with done high, and the receiver cannot stall it. An add to a full
// pool and a tick on an empty pool are answered in the cycle after the word is taken,
// with busy staying low. An add that is stored keeps busy high while the valid bits are
// checked one slot a cycle, up to the lowest free slot. A tick that runs a job keeps
// busy high while the single read port of the time store feeds one comparator one entry
// per cycle, then through S_LAST and S_WRITE, where the decremented time is written back.
// The result appears in the same cycle as busy falls.
module shortest_remaining_time_scheduler #(
	parameter int CAPACITY = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [15:0]                      service_time,
	output logic                             done,
	output logic                             accepted,
	output logic                             ran,
	output logic [15:0]                      remaining,
	output logic                             finished,
	output logic [4:0]                       occupancy
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	srt_pkg::state_t               state_q, state_d;
	logic [CAPACITY-1:0]           valid_q;
	logic [CW-1:0]                 count_q;
	logic [IW-1:0]                 idx_q;
	logic [srt_pkg::TIME_W-1:0]    svc_q;

	logic                          sample_s1;
	logic                          valid_s1;
	logic [IW-1:0]                 idx_s1;

	logic                          take_word;
	logic                          pool_full;
	logic                          pool_empty;
	logic                          idx_last;
	logic                          slot_free;

	logic [srt_pkg::TIME_W-1:0]    rd_data;
	logic                          wr_en;
	logic [IW-1:0]                 wr_addr;
	logic [srt_pkg::TIME_W-1:0]    wr_data;

	srt_pkg::scan_ctl_t            scan_ctl;
	logic [srt_pkg::TIME_W-1:0]    best_time;
	logic [IW-1:0]                 best_idx;
	logic [srt_pkg::TIME_W-1:0]    dec_time;
	logic                          dec_zero;
	logic [CW-1:0]                 count_after;
	logic [31:0]                   count_ext;

	logic                          done_q;
	logic                          accepted_q;
	logic                          ran_q;
	logic [srt_pkg::TIME_W-1:0]    remaining_q;
	logic                          finished_q;
	logic [srt_pkg::OCC_W-1:0]     occupancy_q;

	assign busy       = (state_q != srt_pkg::S_IDLE);
	assign take_word  = start && !busy;
	assign pool_full  = (count_q == CW'(CAPACITY));
	assign pool_empty = (count_q == '0);
	assign idx_last   = (idx_q == IW'(CAPACITY - 1));
	assign slot_free  = !valid_q[idx_q];

	// saturating decrement of the chosen job
	assign dec_time = (best_time == '0) ? '0 : best_time - 1'b1;
	assign dec_zero = (dec_time == '0);

	// job count once the current word has been handled
	always_comb begin
		count_after = count_q;
		if (state_q == srt_pkg::S_ADD && slot_free) begin
			count_after = count_q + 1'b1;
		end else if (state_q == srt_pkg::S_WRITE && dec_zero) begin
			count_after = count_q - 1'b1;
		end
	end
	assign count_ext = 32'(count_after);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srt_pkg::S_IDLE: begin
				if (take_word) begin
					if (action == srt_pkg::ACT_ADD && !pool_full) begin
						state_d = srt_pkg::S_ADD;
					end else if (action == srt_pkg::ACT_TICK && !pool_empty) begin
						state_d = srt_pkg::S_SCAN;
					end
				end
			end
			srt_pkg::S_ADD: begin
				if (slot_free) begin
					state_d = srt_pkg::S_IDLE;
				end
			end
			srt_pkg::S_SCAN: begin
				if (idx_last) begin
					state_d = srt_pkg::S_LAST;
				end
			end
			srt_pkg::S_LAST:  state_d = srt_pkg::S_WRITE;
			srt_pkg::S_WRITE: state_d = srt_pkg::S_IDLE;
			default:          state_d = srt_pkg::S_IDLE;
		endcase
	end

	// state, slot index and read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= srt_pkg::S_IDLE;
			idx_q     <= '0;
			sample_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			sample_s1 <= (state_q == srt_pkg::S_SCAN);
			if (take_word) begin
				idx_q <= '0;
			end else if (state_q == srt_pkg::S_SCAN ||
			             (state_q == srt_pkg::S_ADD && !slot_free)) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	// payload travelling with each read
	always_ff @(posedge clk) begin
		valid_s1 <= valid_q[idx_q];
		idx_s1   <= idx_q;
		if (take_word) begin
			svc_q <= service_time;
		end
	end

	// valid bits and job count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_after;
			if (state_q == srt_pkg::S_ADD && slot_free) begin
				valid_q[idx_q] <= 1'b1;
			end else if (state_q == srt_pkg::S_WRITE && dec_zero) begin
				valid_q[best_idx] <= 1'b0;
			end
		end
	end

	// write port: new job on add, decremented time on tick
	assign wr_en   = (state_q == srt_pkg::S_ADD && slot_free) || (state_q == srt_pkg::S_WRITE);
	assign wr_addr = (state_q == srt_pkg::S_WRITE) ? best_idx : idx_q;
	assign wr_data = (state_q == srt_pkg::S_WRITE) ? dec_time : svc_q;

	srt_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk     (clk),
		.rd_en   (state_q == srt_pkg::S_SCAN),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign scan_ctl.clear  = take_word;
	assign scan_ctl.sample = sample_s1;
	assign scan_ctl.valid  = valid_s1;

	srt_scan #(
		.CAPACITY (CAPACITY)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.rd_data   (rd_data),
		.idx_s1    (idx_s1),
		.best_time (best_time),
		.best_idx  (best_idx)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (take_word && ((action == srt_pkg::ACT_ADD && pool_full) ||
			                         (action == srt_pkg::ACT_TICK && pool_empty))) ||
			          (state_q == srt_pkg::S_ADD && slot_free) ||
			          (state_q == srt_pkg::S_WRITE);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (take_word) begin
			accepted_q  <= 1'b0;
			ran_q       <= 1'b0;
			remaining_q <= '0;
			finished_q  <= 1'b0;
			occupancy_q <= count_ext[srt_pkg::OCC_W-1:0];
		end else if (state_q == srt_pkg::S_ADD && slot_free) begin
			accepted_q  <= 1'b1;
			occupancy_q <= count_ext[srt_pkg::OCC_W-1:0];
		end else if (state_q == srt_pkg::S_WRITE) begin
			ran_q       <= 1'b1;
			remaining_q <= dec_time;
			finished_q  <= dec_zero;
			occupancy_q <= count_ext[srt_pkg::OCC_W-1:0];
		end
	end

	assign done      = done_q;
	assign accepted  = accepted_q;
	assign ran       = ran_q;
	assign remaining = remaining_q;
	assign finished  = finished_q;
	assign occupancy = occupancy_q;

endmodule

// ===== src/srt_checker.sv =====
// port level checks of the scheduler and their binding to the top level
module srt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic        accepted,
	input logic        ran,
	input logic [15:0] remaining,
	input logic        finished
);

	// a word is either an add or a tick, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(accepted && ran))
		else $error("result reports both a stored add and a run job");

	// only a job that ran can finish, and a finished job has no time left
	a_finish_ran: assert property (@(posedge clk) disable iff (!arst_n)
		done && finished |-> ran && (remaining == 16'd0))
		else $error("finished flag without a run job at zero");

	// a job kept in the pool still has time left
	a_kept_time: assert property (@(posedge clk) disable iff (!arst_n)
		done && ran && !finished |-> (remaining != 16'd0))
		else $error("job kept with no remaining time");

	// the end of a long operation is always followed by its result
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// no run fields on a word that ran nothing
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ran |-> (remaining == 16'd0) && !finished)
		else $error("run fields set on a word that ran nothing");

endmodule

bind shortest_remaining_time_scheduler srt_checker u_srt_checker (.*);

// ===== sim/tb_top.sv =====
// testbench of the scheduler: directed and random words checked against a pool model
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 16;

	// one result word as the block reports it
	typedef struct {
		logic                       accepted;
		logic                       ran;
		logic [srt_pkg::TIME_W-1:0] remaining;
		logic                       finished;
		logic [srt_pkg::OCC_W-1:0]  occupancy;
	} pool_report_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       action;
	logic [srt_pkg::TIME_W-1:0] service_time;
	logic                       done;
	logic                       accepted;
	logic                       ran;
	logic [srt_pkg::TIME_W-1:0] remaining;
	logic                       finished;
	logic [srt_pkg::OCC_W-1:0]  occupancy;

	// own copy of the job pool
	logic [srt_pkg::TIME_W-1:0] job_time [CAPACITY];
	bit                         job_live [CAPACITY];
	int unsigned                job_total;

	pool_report_t due_reports[$];
	int           fail_count = 0;
	bit           back_to_back = 1'b0;

	shortest_remaining_time_scheduler #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.service_time(service_time),
		.done(done),
		.accepted(accepted),
		.ran(ran),
		.remaining(remaining),
		.finished(finished),
		.occupancy(occupancy)
	);

	always #5 clk = ~clk;

	// advance the pool model by one word and queue the report it should give
	task automatic schedule_job(input logic act, input logic [srt_pkg::TIME_W-1:0] svc);
		pool_report_t r;
		int slot;
		r = '{default: '0};
		slot = -1;
		if (act == srt_pkg::ACT_ADD) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (!job_live[i] && slot < 0) slot = i;
			end
			if (slot >= 0) begin
				job_time[slot] = svc;
				job_live[slot] = 1'b1;
				job_total++;
				r.accepted = 1'b1;
			end
		end else begin
			// least time wins, lowest slot on a tie
			for (int i = 0; i < CAPACITY; i++) begin
				if (job_live[i] && (slot < 0 || job_time[i] < job_time[slot])) slot = i;
			end
			if (slot >= 0) begin
				if (job_time[slot] != '0) job_time[slot] = job_time[slot] - 1'b1;
				r.ran = 1'b1;
				r.remaining = job_time[slot];
				if (job_time[slot] == '0) begin
					job_live[slot] = 1'b0;
					if (job_total > 0) job_total--;
					r.finished = 1'b1;
				end
			end
		end
		r.occupancy = job_total[srt_pkg::OCC_W-1:0];
		due_reports.push_back(r);
	endtask

	// present one word and hold it until the block takes it
	task automatic send_word(input logic act, input logic [srt_pkg::TIME_W-1:0] svc);
		int gap;
		gap = back_to_back ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		service_time <= svc;
		do @(posedge clk); while (busy);
		schedule_job(act, svc);
	endtask

	// stop sending until every queued report has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (due_reports.size() != 0) @(posedge clk);
		repeat (CAPACITY + 4) @(posedge clk);
	endtask

	// mostly short jobs so the pool turns over; wide values where the block drops them
	function automatic logic [srt_pkg::TIME_W-1:0] pick_service_time(input logic act);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (act == srt_pkg::ACT_TICK || job_total >= CAPACITY) begin
			return srt_pkg::TIME_W'($urandom());
		end
		if (r < 2) return '0;
		if (r < 80) return srt_pkg::TIME_W'($urandom_range(1, 6));
		if (r < 97) return srt_pkg::TIME_W'($urandom_range(7, 40));
		return srt_pkg::TIME_W'($urandom_range(41, 200));
	endfunction

	task automatic report_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// compare each reported word with the oldest one queued
	always @(posedge clk) begin
		pool_report_t want;
		if (done) begin
			if (due_reports.size() == 0) begin
				$display("%0t: word expected none, got acc=%0b ran=%0b rem=%0d fin=%0b occ=%0d",
					$time, accepted, ran, remaining, finished, occupancy);
				fail_count++;
			end else begin
				want = due_reports.pop_front();
				report_field("accepted", 32'(want.accepted), 32'(accepted));
				report_field("ran", 32'(want.ran), 32'(ran));
				report_field("remaining", 32'(want.remaining), 32'(remaining));
				report_field("finished", 32'(want.finished), 32'(finished));
				report_field("occupancy", 32'(want.occupancy), 32'(occupancy));
			end
		end
	end

	// tick on an empty pool runs nothing
	task automatic test_empty_tick();
		send_word(srt_pkg::ACT_TICK, 16'hFFFF);
	endtask

	// a job of zero time retires on its first run
	task automatic test_zero_time();
		send_word(srt_pkg::ACT_ADD, 16'h0000);
		send_word(srt_pkg::ACT_TICK, 16'h0000);
	endtask

	// equal times: either pick gives the same word
	task automatic test_ties();
		send_word(srt_pkg::ACT_ADD, 16'd3);
		send_word(srt_pkg::ACT_ADD, 16'd3);
		send_word(srt_pkg::ACT_TICK, 16'h0000);
		send_word(srt_pkg::ACT_TICK, 16'h0000);
		hold_until_drained();
	endtask

	// fill the pool back to back, then adds are dropped and a tick still runs
	task automatic test_full_pool();
		back_to_back = 1'b1;
		while (job_total < CAPACITY) begin
			send_word(srt_pkg::ACT_ADD, srt_pkg::TIME_W'($urandom_range(1, 9)));
		end
		send_word(srt_pkg::ACT_ADD, 16'hFFFF);
		send_word(srt_pkg::ACT_ADD, 16'h5555);
		send_word(srt_pkg::ACT_TICK, 16'hAAAA);
		back_to_back = 1'b0;
		hold_until_drained();
	endtask

	// random mix in blocks, swinging between filling and draining the pool
	task automatic test_random();
		int add_pct;
		logic act;
		for (int blk = 0; blk < 20; blk++) begin
			case (blk % 4)
				0: add_pct = 90;
				1: add_pct = 10;
				default: add_pct = $urandom_range(20, 80);
			endcase
			back_to_back = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 100; n++) begin
				act = ($urandom_range(0, 99) < add_pct) ? srt_pkg::ACT_ADD : srt_pkg::ACT_TICK;
				send_word(act, pick_service_time(act));
			end
			if (blk == 9) hold_until_drained();
		end
		back_to_back = 1'b0;
	endtask

	// empty the pool, then run jobs with the widest times
	task automatic test_wide_time();
		while (job_total != 0) send_word(srt_pkg::ACT_TICK, srt_pkg::TIME_W'($urandom()));
		send_word(srt_pkg::ACT_ADD, 16'hFFFF);
		send_word(srt_pkg::ACT_TICK, 16'h0000);
		send_word(srt_pkg::ACT_ADD, 16'h8000);
		send_word(srt_pkg::ACT_TICK, 16'hFFFF);
		send_word(srt_pkg::ACT_ADD, 16'h0001);
		send_word(srt_pkg::ACT_TICK, 16'h0000);
	endtask

	initial begin
		start = 1'b0;
		action = srt_pkg::ACT_ADD;
		service_time = '0;
		arst_n = 1'b0;
		for (int i = 0; i < CAPACITY; i++) job_live[i] = 1'b0;
		job_total = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tick();
		test_zero_time();
		test_ties();
		test_full_pool();
		test_random();
		test_wide_time();

		hold_until_drained();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hang guard
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
